// File: rtl/core/tcpq_pkg.sv
// Shared types, codes and the expiry test for the three-class priority queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package tcpq_pkg;

	localparam int LIMIT_W = 6;

	// Request codes.
	localparam logic [1:0] REQ_ENQ   = 2'd0;
	localparam logic [1:0] REQ_DEQ   = 2'd1;
	localparam logic [1:0] REQ_PURGE = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// Class codes, also used as priority codes.
	localparam logic [1:0] CLS_LOW  = 2'd0;
	localparam logic [1:0] CLS_MED  = 2'd1;
	localparam logic [1:0] CLS_HIGH = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_DUPLICATE  = 3'd1;
	localparam logic [2:0] ST_TOTAL_FULL = 3'd2;
	localparam logic [2:0] ST_CLASS_FULL = 3'd3;
	localparam logic [2:0] ST_EMPTY      = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] current_tick;
		logic [31:0] prompt_key;
		logic [1:0]  priority_req;
		logic [31:0] enqueued_tick;
		logic [15:0] timeout_ticks;
	} tcpq_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_id;
		logic [31:0] out_key;
		logic [1:0]  out_class;
		logic [5:0]  expired_count;
		logic [4:0]  high_count;
		logic [4:0]  medium_count;
		logic [4:0]  low_count;
		logic        any_ready;
	} tcpq_out_t;

	// One stored request.
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] stamp;
		logic [15:0] limit;
		logic [31:0] ident;
	} tcpq_entry_t;

	// An entry expires when its signed age is positive and above its limit.
	function automatic logic slot_expired(input logic [31:0] now, input logic [31:0] stamp,
			input logic [15:0] limit);
		logic [31:0] age;
		age = now - stamp;
		return !age[31] && (age > {16'd0, limit});
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/three_class_priority_queue_timeout_unit.sv
// Time from the accepting edge to the result word: enqueue and purge grow with the number N
// of entries held, a dequeue that pops an entry also with the fill M of the popped class after
// the purge, and clear walks no entries. The walks go through the single read port of the
// entry memory, one entry a cycle.
// One request is in work at a time; a finished word waits in the output register while the
// next is taken. Reset empties all classes, zeroes the id counter and sets the limit to 48.
`default_nettype none
module three_class_priority_queue_timeout_unit #(
	parameter int HIGH_DEPTH = 16,
	parameter int MEDIUM_DEPTH = 16,
	parameter int LOW_DEPTH = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [5:0]          cfg_data,
	input  wire                 in_valid,
	output logic                in_ready,
	input  tcpq_pkg::tcpq_in_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output tcpq_pkg::tcpq_out_t out_data
);
	import tcpq_pkg::*;

	localparam int TOTAL = LOW_DEPTH + MEDIUM_DEPTH + HIGH_DEPTH;
	localparam int AW = $clog2(TOTAL);
	localparam int MAX_HM = (HIGH_DEPTH > MEDIUM_DEPTH) ? HIGH_DEPTH : MEDIUM_DEPTH;
	localparam int MAX_D = (MAX_HM > LOW_DEPTH) ? MAX_HM : LOW_DEPTH;
	localparam int FW = $clog2(MAX_D + 1);
	localparam int TW = (FW + 2 > LIMIT_W) ? FW + 2 : LIMIT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_ENQ, S_PURGE, S_DQ_SEL, S_DQ_WALK, S_RESP
	} state_t;

	state_t          state_q;
	tcpq_in_t        req_q;
	logic [1:0]      cls_q;
	logic [FW-1:0]   rd_idx_q;
	logic [FW-1:0]   keep_q;
	logic [FW-1:0]   fill_q [3];
	logic [5:0]      exp_cnt_q;
	logic            dup_q;
	logic            any_q;
	logic [31:0]     next_id_q;
	logic [5:0]      limit_q;
	logic [2:0]      status_q;
	logic [31:0]     res_id_q;
	logic [31:0]     res_key_q;
	logic [1:0]      res_class_q;
	logic            rd_vld_s1;
	logic [FW-1:0]   rd_idx_s1;
	logic            out_valid_q;
	tcpq_out_t       out_data_q;

	logic [AW-1:0]   cur_base;
	logic [FW-1:0]   cur_fill;
	logic            walking;
	logic            issue;
	logic            walk_done;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	tcpq_entry_t     wr_data;
	tcpq_entry_t     rd_data;
	logic [AW-1:0]   rd_addr;
	logic            data_exp;
	logic [1:0]      enq_cls;
	logic [AW-1:0]   enq_base;
	logic [FW-1:0]   enq_cap;
	logic [TW-1:0]   total;
	logic            enq_room;
	logic            enq_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Base address and fill of the class being walked.
	always_comb begin
		case (cls_q)
			CLS_LOW:  cur_base = AW'(0);
			CLS_MED:  cur_base = AW'(LOW_DEPTH);
			CLS_HIGH: cur_base = AW'(LOW_DEPTH + MEDIUM_DEPTH);
			default:  cur_base = AW'(0);
		endcase
		cur_fill = fill_q[cls_q];
	end

	// Class chosen by an enqueue; the unknown priority goes to medium.
	always_comb begin
		case (req_q.priority_req)
			CLS_LOW: begin
				enq_cls  = CLS_LOW;
				enq_base = AW'(0);
				enq_cap  = FW'(LOW_DEPTH);
			end
			CLS_HIGH: begin
				enq_cls  = CLS_HIGH;
				enq_base = AW'(LOW_DEPTH + MEDIUM_DEPTH);
				enq_cap  = FW'(HIGH_DEPTH);
			end
			default: begin
				enq_cls  = CLS_MED;
				enq_base = AW'(LOW_DEPTH);
				enq_cap  = FW'(MEDIUM_DEPTH);
			end
		endcase
		total = TW'(fill_q[0]) + TW'(fill_q[1]) + TW'(fill_q[2]);
		enq_room = fill_q[enq_cls] < enq_cap;
		enq_ok = !dup_q && (total < TW'(limit_q));
	end

	// Walk control: one read issued a cycle, its data processed in the cycle after.
	assign walking   = (state_q == S_SCAN) || (state_q == S_PURGE) || (state_q == S_DQ_WALK);
	assign issue     = walking && (rd_idx_q < cur_fill);
	assign walk_done = walking && !issue && !rd_vld_s1;
	assign rd_addr   = cur_base + AW'(rd_idx_q);
	assign data_exp  = slot_expired(req_q.current_tick, rd_data.stamp, rd_data.limit);

	// Write port: compaction during purge, shift during dequeue, new entry on enqueue.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_base + AW'(keep_q);
		wr_data = rd_data;
		case (state_q)
			S_PURGE: begin
				wr_en = rd_vld_s1 && !data_exp;
			end
			S_DQ_WALK: begin
				wr_en   = rd_vld_s1 && (rd_idx_s1 != '0);
				wr_addr = cur_base + AW'(rd_idx_s1) - AW'(1);
			end
			S_ENQ: begin
				wr_en   = enq_ok && enq_room;
				wr_addr = enq_base + AW'(fill_q[enq_cls]);
				wr_data = '{key: req_q.prompt_key, stamp: req_q.enqueued_tick,
					limit: req_q.timeout_ticks, ident: next_id_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	tcpq_slot_mem #(.DEPTH(TOTAL), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer, class fills, id counter and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			cls_q       <= CLS_LOW;
			rd_idx_q    <= '0;
			keep_q      <= '0;
			for (int i = 0; i < 3; i++) fill_q[i] <= '0;
			exp_cnt_q   <= '0;
			dup_q       <= 1'b0;
			any_q       <= 1'b0;
			next_id_q   <= '0;
			limit_q     <= 6'd48;
			status_q    <= ST_OK;
			res_id_q    <= '0;
			res_key_q   <= '0;
			res_class_q <= CLS_LOW;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Read pipeline bookkeeping.
			rd_vld_s1 <= issue;
			rd_idx_s1 <= rd_idx_q;
			if (issue) begin
				rd_idx_q <= rd_idx_q + FW'(1);
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q       <= in_data;
						cls_q       <= CLS_LOW;
						rd_idx_q    <= '0;
						keep_q      <= '0;
						exp_cnt_q   <= '0;
						dup_q       <= 1'b0;
						any_q       <= 1'b0;
						status_q    <= ST_OK;
						res_id_q    <= '0;
						res_key_q   <= '0;
						res_class_q <= CLS_LOW;
						case (in_data.req_type)
							REQ_ENQ: state_q <= S_SCAN;
							REQ_CLEAR: begin
								for (int i = 0; i < 3; i++) fill_q[i] <= '0;
								state_q <= S_RESP;
							end
							default: state_q <= S_PURGE;
						endcase
					end
				end
				S_SCAN: begin
					// Duplicate keys and unexpired entries across all classes.
					if (rd_vld_s1) begin
						if (rd_data.key == req_q.prompt_key) dup_q <= 1'b1;
						if (!data_exp) any_q <= 1'b1;
					end
					if (walk_done) begin
						rd_idx_q <= '0;
						if (cls_q == CLS_HIGH) begin
							state_q <= S_ENQ;
						end else begin
							cls_q <= cls_q + 2'd1;
						end
					end
				end
				S_ENQ: begin
					if (dup_q) begin
						status_q <= ST_DUPLICATE;
					end else if (!enq_ok) begin
						status_q <= ST_TOTAL_FULL;
					end else begin
						next_id_q <= next_id_q + 32'd1;
						if (enq_room) begin
							fill_q[enq_cls] <= fill_q[enq_cls] + FW'(1);
							res_id_q <= next_id_q;
							if (!slot_expired(req_q.current_tick, req_q.enqueued_tick,
									req_q.timeout_ticks)) begin
								any_q <= 1'b1;
							end
						end else begin
							status_q <= ST_CLASS_FULL;
						end
					end
					state_q <= S_RESP;
				end
				S_PURGE: begin
					// Expired entries are dropped, the rest move down in order.
					if (rd_vld_s1) begin
						if (data_exp) begin
							exp_cnt_q <= exp_cnt_q + 6'd1;
						end else begin
							keep_q <= keep_q + FW'(1);
						end
					end
					if (walk_done) begin
						fill_q[cls_q] <= keep_q;
						keep_q   <= '0;
						rd_idx_q <= '0;
						if (cls_q == CLS_HIGH) begin
							state_q <= S_DQ_SEL;
						end else begin
							cls_q <= cls_q + 2'd1;
						end
					end
				end
				S_DQ_SEL: begin
					// Every entry left after a purge is unexpired.
					any_q    <= (total != '0);
					rd_idx_q <= '0;
					if (req_q.req_type != REQ_DEQ) begin
						state_q <= S_RESP;
					end else if (fill_q[2] != '0) begin
						cls_q   <= CLS_HIGH;
						state_q <= S_DQ_WALK;
					end else if (fill_q[1] != '0) begin
						cls_q   <= CLS_MED;
						state_q <= S_DQ_WALK;
					end else if (fill_q[0] != '0) begin
						cls_q   <= CLS_LOW;
						state_q <= S_DQ_WALK;
					end else begin
						status_q <= ST_EMPTY;
						state_q  <= S_RESP;
					end
				end
				S_DQ_WALK: begin
					// The head is returned and the rest of the class shifts down.
					if (rd_vld_s1 && (rd_idx_s1 == '0)) begin
						res_id_q    <= rd_data.ident;
						res_key_q   <= rd_data.key;
						res_class_q <= cls_q;
					end
					if (walk_done) begin
						fill_q[cls_q] <= cur_fill - FW'(1);
						any_q   <= (total != TW'(1));
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= '{status: status_q, out_id: res_id_q, out_key: res_key_q,
							out_class: res_class_q, expired_count: exp_cnt_q,
							high_count: 5'(fill_q[2]), medium_count: 5'(fill_q[1]),
							low_count: 5'(fill_q[0]), any_ready: any_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/tcpq_slot_mem.sv
// Entry storage of the queue: one write port and one registered read port.
// Depends on tcpq_pkg for the entry type.
`default_nettype none
module tcpq_slot_mem #(
	parameter int DEPTH = 48,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire                    clk,
	input  wire                    wr_en,
	input  wire  [AW-1:0]          wr_addr,
	input  tcpq_pkg::tcpq_entry_t  wr_data,
	input  wire  [AW-1:0]          rd_addr,
	output tcpq_pkg::tcpq_entry_t  rd_data
);
	import tcpq_pkg::*;

	tcpq_entry_t mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// File: rtl/core/tcpq_checker.sv
// Port-level checks for the three-class priority queue, bound to its top level.
// Depends on tcpq_pkg for the result word and status codes.
`default_nettype none
module tcpq_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input tcpq_pkg::tcpq_out_t out_data
);
	import tcpq_pkg::*;

	// A word that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	// The block works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// An empty dequeue leaves every class empty and carries no entry.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_EMPTY) |->
		(out_data.out_id == 32'd0) && (out_data.out_class == CLS_LOW) &&
		(out_data.high_count == 5'd0) && (out_data.medium_count == 5'd0) &&
		(out_data.low_count == 5'd0) && !out_data.any_ready)
		else $error("empty dequeue with entries present");

	// Rejected enqueues report no id and no expired entries.
	a_reject_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.status == ST_DUPLICATE) ||
		(out_data.status == ST_TOTAL_FULL) || (out_data.status == ST_CLASS_FULL)) |->
		(out_data.out_id == 32'd0) && (out_data.expired_count == 6'd0))
		else $error("rejected enqueue reports an id");

endmodule

bind three_class_priority_queue_timeout_unit tcpq_checker u_tcpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the three-class priority queue with per-entry timeout.
// Depends on tcpq_pkg and three_class_priority_queue_timeout_unit; reads no files.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import tcpq_pkg::*;

	localparam int DEPTH = 16;
	localparam int SLOTS = 3 * DEPTH;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [5:0] cfg_data;
	logic in_valid;
	logic in_ready;
	tcpq_in_t in_data;
	logic out_valid;
	logic out_ready;
	tcpq_out_t out_data;

	three_class_priority_queue_timeout_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// Shadow copy of the queue contents, class c occupying slots c*DEPTH onward.
	tcpq_entry_t shadow [SLOTS];
	int unsigned fill [3];
	logic [31:0] id_counter;
	logic [5:0] limit_reg;

	tcpq_in_t request_q [$];
	tcpq_out_t result_q [$];
	int errors;
	logic sender_on;
	int in_gap;
	int out_gap;
	int n_accepted;
	int n_queued;

	function automatic logic aged_out(input logic [31:0] now, input tcpq_entry_t e);
		logic [31:0] age;
		age = now - e.stamp;
		return !age[31] && (age > {16'd0, e.limit});
	endfunction

	// Drop expired entries of one class, keeping the order of the rest.
	function automatic int unsigned sweep_class(input int c, input logic [31:0] now);
		int unsigned kept;
		int unsigned gone;
		kept = 0;
		gone = 0;
		for (int i = 0; i < fill[c]; i++) begin
			if (aged_out(now, shadow[c*DEPTH+i]))
				gone++;
			else begin
				shadow[c*DEPTH+kept] = shadow[c*DEPTH+i];
				kept++;
			end
		end
		fill[c] = kept;
		return gone;
	endfunction

	// Apply one request to the shadow queue and return the word it should produce.
	function automatic tcpq_out_t queue_apply(input tcpq_in_t r);
		tcpq_out_t o;
		int c;
		logic hit;
		int unsigned gone;
		o = '0;
		gone = 0;
		if (r.req_type == REQ_ENQ) begin
			c = (r.priority_req == 2'd3) ? int'(CLS_MED) : int'(r.priority_req);
			hit = 0;
			for (int k = 0; k < 3; k++)
				for (int i = 0; i < fill[k]; i++)
					if (shadow[k*DEPTH+i].key == r.prompt_key)
						hit = 1;
			if (hit)
				o.status = ST_DUPLICATE;
			else if (fill[0] + fill[1] + fill[2] >= limit_reg)
				o.status = ST_TOTAL_FULL;
			else begin
				// The id is used up even when the class turns out to be full.
				if (fill[c] < DEPTH) begin
					shadow[c*DEPTH+fill[c]] = '{r.prompt_key, r.enqueued_tick,
						r.timeout_ticks, id_counter};
					fill[c]++;
					o.status = ST_OK;
					o.out_id = id_counter;
				end else
					o.status = ST_CLASS_FULL;
				id_counter = id_counter + 1;
			end
		end else if (r.req_type == REQ_DEQ || r.req_type == REQ_PURGE) begin
			gone = sweep_class(2, r.current_tick) + sweep_class(1, r.current_tick)
				+ sweep_class(0, r.current_tick);
			if (r.req_type == REQ_DEQ) begin
				o.status = ST_EMPTY;
				for (c = 2; c >= 0; c--) begin
					if (fill[c] > 0) begin
						o.status = ST_OK;
						o.out_id = shadow[c*DEPTH].ident;
						o.out_key = shadow[c*DEPTH].key;
						o.out_class = c[1:0];
						for (int i = 1; i < fill[c]; i++)
							shadow[c*DEPTH+i-1] = shadow[c*DEPTH+i];
						fill[c]--;
						break;
					end
				end
			end
		end else begin
			fill[0] = 0;
			fill[1] = 0;
			fill[2] = 0;
		end
		o.expired_count = gone[5:0];
		o.high_count = fill[2][4:0];
		o.medium_count = fill[1][4:0];
		o.low_count = fill[0][4:0];
		o.any_ready = 0;
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < fill[k]; i++)
				if (!aged_out(r.current_tick, shadow[k*DEPTH+i]))
					o.any_ready = 1;
		return o;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		else if (p < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic tcpq_in_t make_req(input logic [1:0] op, input logic [31:0] now,
			input logic [31:0] key, input logic [1:0] pri, input logic [31:0] stamp,
			input logic [15:0] tmo);
		tcpq_in_t r;
		r.req_type = op;
		r.current_tick = now;
		r.prompt_key = key;
		r.priority_req = pri;
		r.enqueued_tick = stamp;
		r.timeout_ticks = tmo;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Input driver: presents queued words, with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_data <= '0;
			in_gap <= 0;
			n_accepted <= 0;
		end else begin
			if (in_valid && in_ready) begin
				result_q.insert(result_q.size(), queue_apply(in_data));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 0;
					in_gap <= in_gap - 1;
				end else if (sender_on && request_q.size() > 0) begin
					in_valid <= 1;
					in_data <= request_q[0];
					request_q.delete(0);
					in_gap <= pick_gap();
				end else
					in_valid <= 0;
			end
		end
	end

	// Output monitor: compares each word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_data);
					errors++;
				end else begin
					tcpq_out_t e;
					e = result_q[0];
					result_q.delete(0);
					if (e !== out_data) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_ready <= 0;
				out_gap <= out_gap - 1;
			end else begin
				out_ready <= 1;
				out_gap <= pick_gap();
			end
		end
	end

	task automatic wait_drained();
		while (n_accepted < n_queued || result_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_limit(input logic [5:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		limit_reg = v;
	endtask

	task automatic add(input tcpq_in_t r);
		request_q.insert(request_q.size(), r);
		n_queued++;
	endtask

	// Random phase: mostly enqueue and dequeue traffic on a small key space.
	task automatic random_phase(input int count);
		logic [31:0] now;
		logic [31:0] k;
		int p;
		now = $urandom;
		for (int i = 0; i < count; i++) begin
			now = now + $urandom_range(0, 40);
			p = $urandom_range(0, 99);
			k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
			if (p < 55)
				add(make_req(REQ_ENQ, now, k, 2'($urandom_range(0, 3)),
					now - 32'($urandom_range(0, 30)) +
					(($urandom_range(0, 9) == 0) ? $urandom : 32'd0),
					($urandom_range(0, 9) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 300))));
			else if (p < 85)
				add(make_req(REQ_DEQ, now, $urandom, 2'($urandom), $urandom, 16'($urandom)));
			else if (p < 97)
				add(make_req(REQ_PURGE, now, $urandom, 2'($urandom), $urandom,
					16'($urandom)));
			else
				add(make_req(REQ_CLEAR, now, $urandom, 2'($urandom), $urandom,
					16'($urandom)));
		end
	endtask

	initial begin
		errors = 0;
		n_queued = 0;
		sender_on = 0;
		fill[0] = 0;
		fill[1] = 0;
		fill[2] = 0;
		id_counter = 0;
		limit_reg = 6'd48;
		cfg_valid = 0;
		cfg_data = '0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// Directed words: every operation, all priorities, field extremes, duplicates,
		// empty dequeue, expiry, a negative age and a full class.
		add(make_req(REQ_DEQ, 32'd0, 32'd0, 2'd0, 32'd0, 16'd0));
		add(make_req(REQ_ENQ, 32'd100, 32'hFFFFFFFF, CLS_LOW, 32'd100, 16'hFFFF));
		add(make_req(REQ_ENQ, 32'd100, 32'd0, CLS_MED, 32'd100, 16'd0));
		add(make_req(REQ_ENQ, 32'd100, 32'd5, CLS_HIGH, 32'd90, 16'd5));
		add(make_req(REQ_ENQ, 32'd100, 32'd6, 2'd3, 32'd200, 16'd1));
		add(make_req(REQ_ENQ, 32'd100, 32'd5, CLS_LOW, 32'd100, 16'd10));
		add(make_req(REQ_PURGE, 32'd101, 32'hFFFFFFFF, 2'd3, 32'hFFFFFFFF, 16'hFFFF));
		add(make_req(REQ_DEQ, 32'd101, 32'd0, 2'd0, 32'd0, 16'd0));
		add(make_req(REQ_DEQ, 32'hFFFFFFFF, 32'd0, 2'd0, 32'd0, 16'd0));
		for (int i = 0; i < 17; i++)
			add(make_req(REQ_ENQ, 32'd50, 32'd1000 + i, CLS_HIGH, 32'd50, 16'd100));
		add(make_req(REQ_CLEAR, 32'd50, 32'd0, 2'd0, 32'd0, 16'd0));
		sender_on = 1;
		wait_drained();

		// Limits of 0, 5, 63 and 48, with the sender held until all words are back between phases.
		sender_on = 0;
		write_limit(6'd0);
		sender_on = 1;
		add(make_req(REQ_ENQ, 32'd1, 32'd77, CLS_LOW, 32'd1, 16'd9));
		random_phase(60);
		wait_drained();
		sender_on = 0;
		write_limit(6'd5);
		sender_on = 1;
		random_phase(200);
		wait_drained();
		sender_on = 0;
		write_limit(6'd63);
		sender_on = 1;
		random_phase(320);
		wait_drained();
		sender_on = 0;
		write_limit(6'd48);
		sender_on = 1;
		random_phase(300);
		wait_drained();

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_slot_mem.sv
rtl/core/three_class_priority_queue_timeout_unit.sv
rtl/core/tcpq_checker.sv
bench/tb.sv
